// File: src/htif_host_target_interface_assert.svh
// Assertion macros for the HTIF register block.
// Used by the top level only; needs a clock and an active-low reset in scope.
`ifndef HTIF_HOST_TARGET_INTERFACE_ASSERT_SVH
`define HTIF_HOST_TARGET_INTERFACE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HTIF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define HTIF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/htif_pkg.sv
// Shared types and codes for the HTIF register block.
// No dependencies; used by the channel interfaces and the top level.
package htif_pkg;

	// Field widths
	localparam int unsigned WORD_W   = 64;
	localparam int unsigned OFFSET_W = 12;
	localparam int unsigned SIZE_W   = 2;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned STATUS_W = 2;

	typedef logic [1:0]          cfg_idx_t;
	typedef logic [WORD_W-1:0]   word_t;
	typedef logic [OFFSET_W-1:0] offset_t;
	typedef logic [SIZE_W-1:0]   size_t;
	typedef logic [CHAR_W-1:0]   char_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Configuration register indexes
	localparam cfg_idx_t REG_HALT_MASK    = 2'd0;
	localparam cfg_idx_t REG_CONSOLE_MASK = 2'd1;
	localparam cfg_idx_t REG_YIELD_MASK   = 2'd2;
	localparam cfg_idx_t REG_SUPPRESS     = 2'd3;

	// Access opcodes and sizes
	localparam logic  OP_READ   = 1'b0;
	localparam size_t SIZE_WORD = 2'd3;

	// Register offsets
	localparam offset_t OFF_TOHOST   = 12'd0;
	localparam offset_t OFF_FROMHOST = 12'd8;
	localparam offset_t OFF_IHALT    = 12'd16;
	localparam offset_t OFF_ICONSOLE = 12'd24;
	localparam offset_t OFF_IYIELD   = 12'd32;

	// Devices and commands
	localparam int unsigned DEV_HALT    = 0;
	localparam int unsigned DEV_CONSOLE = 1;
	localparam int unsigned DEV_YIELD   = 2;
	localparam int unsigned CMD_HALT    = 0;
	localparam int unsigned CON_GETCHAR = 0;
	localparam int unsigned CON_PUTCHAR = 1;
	localparam int unsigned YLD_AUTO    = 0;
	localparam int unsigned YLD_MANUAL  = 1;

	// Response status codes
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FAULT = 2'd1;
	localparam status_t ST_HALT  = 2'd2;
	localparam status_t ST_YIELD = 2'd3;

	// Reset value of the halt enable mask
	localparam word_t HALT_MASK_RESET = 64'd1;

endpackage

// File: src/htif_ifs.sv
// Valid/ready channel interfaces for HTIF bus accesses and their responses.
// Depends on htif_pkg for field types.
interface htif_req_if;
	import htif_pkg::*;

	logic    valid;
	logic    ready;
	logic    opcode;
	offset_t byte_offset;
	size_t   size_log2;
	word_t   write_data;
	logic    console_in_valid;
	char_t   console_in_char;

	modport source (output valid, opcode, byte_offset, size_log2, write_data,
		console_in_valid, console_in_char, input ready);
	modport sink (input valid, opcode, byte_offset, size_log2, write_data,
		console_in_valid, console_in_char, output ready);
endinterface

interface htif_rsp_if;
	import htif_pkg::*;

	logic    valid;
	logic    ready;
	word_t   read_data;
	status_t status;
	logic    console_out_valid;
	char_t   console_out_char;
	logic    halt_flag;
	logic    manual_yield_flag;
	logic    auto_yield_flag;

	modport source (output valid, read_data, status, console_out_valid, console_out_char,
		halt_flag, manual_yield_flag, auto_yield_flag, input ready);
	modport sink (input valid, read_data, status, console_out_valid, console_out_char,
		halt_flag, manual_yield_flag, auto_yield_flag, output ready);
endinterface

// File: src/htif_host_target_interface.sv
// HTIF register block: input register, then decode into the response and state
// registers; the response is valid once a decoded access is loaded into them.
// Throughput: one access per cycle unless stalled; the response register and input stage
// advance together, so a stalled response holds only the stage behind it.
// Reset (arst_n low, asynchronous): pipeline empty, tohost/fromhost and flags
// cleared, halt mask 1, other masks and putchar suppression 0.
`include "htif_host_target_interface_assert.svh"

module htif_host_target_interface #(
	parameter int unsigned DEVICE_SHIFT  = 56,
	parameter int unsigned COMMAND_SHIFT = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	htif_req_if.sink          req,
	htif_rsp_if.source        rsp,
	input  logic              cfg_we,
	input  htif_pkg::cfg_idx_t cfg_index,
	input  htif_pkg::word_t   cfg_data
);
	import htif_pkg::*;

	localparam int unsigned DEV_W = WORD_W - DEVICE_SHIFT;
	localparam int unsigned CMD_W = DEVICE_SHIFT - COMMAND_SHIFT;
	localparam int unsigned DAT_W = COMMAND_SHIFT;

	// Configuration registers
	word_t halt_mask_q, console_mask_q, yield_mask_q;
	logic  suppress_q;

	// Architectural state
	word_t tohost_q, fromhost_q;
	logic  halted_q, yield_manual_q, yield_auto_q;

	// Input stage
	logic    valid_s1;
	logic    opcode_s1;
	offset_t offset_s1;
	size_t   size_s1;
	word_t   wdata_s1;
	logic    cin_valid_s1;
	char_t   cin_char_s1;

	// Response register
	logic    rsp_valid_q;
	word_t   rdata_q;
	status_t status_q;
	logic    cout_valid_q;
	char_t   cout_char_q;

	// Decode results
	word_t   rdata_d, tohost_d, fromhost_d;
	status_t status_d;
	logic    cout_valid_d;
	char_t   cout_char_d;
	logic    halted_d, yield_manual_d, yield_auto_d;

	logic [DEV_W-1:0] dev;
	logic [CMD_W-1:0] cmd;
	logic [DAT_W-1:0] dat;
	logic [CHAR_W:0]  getchar_val;
	logic             advance;

	// Stage moves when the response slot is free or being emptied
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_mask_q    <= HALT_MASK_RESET;
			console_mask_q <= '0;
			yield_mask_q   <= '0;
			suppress_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HALT_MASK:    halt_mask_q    <= cfg_data;
				REG_CONSOLE_MASK: console_mask_q <= cfg_data;
				REG_YIELD_MASK:   yield_mask_q   <= cfg_data;
				REG_SUPPRESS:     suppress_q     <= cfg_data[0];
			endcase
		end
	end

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			opcode_s1    <= req.opcode;
			offset_s1    <= req.byte_offset;
			size_s1      <= req.size_log2;
			wdata_s1     <= req.write_data;
			cin_valid_s1 <= req.console_in_valid;
			cin_char_s1  <= req.console_in_char;
		end
	end

	// tohost word fields
	assign dev         = wdata_s1[WORD_W-1:DEVICE_SHIFT];
	assign cmd         = wdata_s1[DEVICE_SHIFT-1:COMMAND_SHIFT];
	assign dat         = wdata_s1[COMMAND_SHIFT-1:0];
	assign getchar_val = cin_valid_s1 ? ({1'b0, cin_char_s1} + (CHAR_W+1)'(1)) : '0;

	// Access decode and command execution
	always_comb begin
		rdata_d        = '0;
		status_d       = ST_OK;
		cout_valid_d   = 1'b0;
		cout_char_d    = '0;
		tohost_d       = tohost_q;
		fromhost_d     = fromhost_q;
		halted_d       = halted_q;
		yield_manual_d = yield_manual_q;
		yield_auto_d   = yield_auto_q;
		if (size_s1 != SIZE_WORD) begin
			status_d = ST_FAULT;
		end else if (opcode_s1 == OP_READ) begin
			unique case (offset_s1)
				OFF_TOHOST:   rdata_d = tohost_q;
				OFF_FROMHOST: rdata_d = fromhost_q;
				OFF_IHALT:    rdata_d = halt_mask_q;
				OFF_ICONSOLE: rdata_d = console_mask_q;
				OFF_IYIELD:   rdata_d = yield_mask_q;
				default:      status_d = ST_FAULT;
			endcase
		end else if (offset_s1 == OFF_FROMHOST) begin
			fromhost_d = wdata_s1;
		end else if (offset_s1 == OFF_TOHOST) begin
			tohost_d = wdata_s1;
			priority if (dev == (DEV_W)'(DEV_HALT)) begin
				// halt needs only data bit 0; no acknowledgement
				if (cmd == (CMD_W)'(CMD_HALT) && dat[0]) begin
					halted_d = 1'b1;
					status_d = ST_HALT;
				end
			end else if (dev == (DEV_W)'(DEV_CONSOLE)) begin
				if (cmd == (CMD_W)'(CON_PUTCHAR) && console_mask_q[CON_PUTCHAR]) begin
					cout_valid_d = !suppress_q;
					cout_char_d  = suppress_q ? '0 : dat[CHAR_W-1:0];
					fromhost_d   = {dev, cmd, (DAT_W)'(0)};
				end else if (cmd == (CMD_W)'(CON_GETCHAR) && console_mask_q[CON_GETCHAR]) begin
					fromhost_d = {dev, cmd, (DAT_W)'(getchar_val)};
				end
			end else if (dev == (DEV_W)'(DEV_YIELD)) begin
				if (cmd == (CMD_W)'(YLD_MANUAL) && yield_mask_q[YLD_MANUAL]) begin
					yield_manual_d = 1'b1;
					status_d       = ST_YIELD;
					fromhost_d     = {dev, cmd, (DAT_W)'(0)};
				end else if (cmd == (CMD_W)'(YLD_AUTO) && yield_mask_q[YLD_AUTO]) begin
					yield_auto_d = 1'b1;
					status_d     = ST_YIELD;
					fromhost_d   = {dev, cmd, (DAT_W)'(0)};
				end
			end else begin
				// unknown device: tohost stored only
			end
		end else begin
			status_d = ST_FAULT;
		end
	end

	// State and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tohost_q       <= '0;
			fromhost_q     <= '0;
			halted_q       <= 1'b0;
			yield_manual_q <= 1'b0;
			yield_auto_q   <= 1'b0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (advance) begin
				tohost_q       <= tohost_d;
				fromhost_q     <= fromhost_d;
				halted_q       <= halted_d;
				yield_manual_q <= yield_manual_d;
				yield_auto_q   <= yield_auto_d;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (advance) begin
			rdata_q      <= rdata_d;
			status_q     <= status_d;
			cout_valid_q <= cout_valid_d;
			cout_char_q  <= cout_char_d;
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.read_data         = rdata_q;
	assign rsp.status            = status_q;
	assign rsp.console_out_valid = cout_valid_q;
	assign rsp.console_out_char  = cout_char_q;
	assign rsp.halt_flag         = halted_q;
	assign rsp.manual_yield_flag = yield_manual_q;
	assign rsp.auto_yield_flag   = yield_auto_q;

	// Checks
	`HTIF_ASSERT_NEXT(a_stall_holds_state, clk, arst_n, rsp_valid_q && !rsp.ready,
		$stable(tohost_q) && $stable(fromhost_q), "state changed under a stalled response")
	`HTIF_ASSERT_NEXT(a_bad_size_no_effect, clk, arst_n, advance && (size_s1 != SIZE_WORD),
		$stable(tohost_q) && $stable(fromhost_q) && status_q == ST_FAULT, "wrong size had effect")
	`HTIF_ASSERT_NOW(a_halt_status_flag, clk, arst_n, rsp_valid_q && status_q == ST_HALT,
		halted_q, "halt status without halted flag")
	`HTIF_ASSERT_NEXT(a_halt_sticky, clk, arst_n, halted_q, halted_q, "halted flag cleared")

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the HTIF register block: random and directed bus accesses.
// Depends on htif_pkg, the channel interfaces in htif_ifs.sv and the block top level.
`timescale 1ns / 1ps

import htif_pkg::*;

localparam int unsigned DEV_SHIFT = 56;
localparam int unsigned CMD_SHIFT = 48;
localparam int unsigned CMD_SLOTS = 64;
localparam word_t CMD_MASK  = (64'd1 << (DEV_SHIFT - CMD_SHIFT)) - 64'd1;
localparam word_t DATA_MASK = (64'd1 << CMD_SHIFT) - 64'd1;
localparam logic OP_WRITE = ~OP_READ;

typedef struct packed {
	logic    opcode;
	offset_t byte_offset;
	size_t   size_log2;
	word_t   write_data;
	logic    console_in_valid;
	char_t   console_in_char;
} access_t;

typedef struct packed {
	word_t   read_data;
	status_t status;
	logic    console_out_valid;
	char_t   console_out_char;
	logic    halt_flag;
	logic    manual_yield_flag;
	logic    auto_yield_flag;
} response_t;

typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

// Shadow copy of the register block plus the queue of responses still owed
class htif_shadow_model;
	word_t halt_mask;
	word_t console_mask;
	word_t yield_mask;
	logic  suppress;
	word_t tohost;
	word_t fromhost;
	logic  halted;
	logic  yld_manual;
	logic  yld_auto;
	response_t owed_rsp[$];
	int errors, n_checked, n_fault, n_halt, n_yield, n_chars;

	function new();
		halt_mask    = HALT_MASK_RESET;
		console_mask = '0;
		yield_mask   = '0;
		suppress     = 1'b0;
		tohost       = '0;
		fromhost     = '0;
		halted       = 1'b0;
		yld_manual   = 1'b0;
		yld_auto     = 1'b0;
	endfunction

	function void set_register(cfg_idx_t idx, word_t val);
		case (idx)
			REG_HALT_MASK:    halt_mask = val;
			REG_CONSOLE_MASK: console_mask = val;
			REG_YIELD_MASK:   yield_mask = val;
			REG_SUPPRESS:     suppress = val[0];
			default: ;
		endcase
	endfunction

	function bit cmd_on(word_t mask, word_t cmd);
		return (cmd < CMD_SLOTS) && mask[cmd[5:0]];
	endfunction

	function word_t ack_word(word_t dev, word_t cmd, word_t data);
		return (dev << DEV_SHIFT) | ((cmd & CMD_MASK) << CMD_SHIFT) | (data & DATA_MASK);
	endfunction

	// Work out the response to one accepted access and update the shadow state
	function void note_access(access_t a);
		response_t r;
		word_t dev, cmd, data, c;
		r    = '0;
		dev  = a.write_data >> DEV_SHIFT;
		cmd  = (a.write_data >> CMD_SHIFT) & CMD_MASK;
		data = a.write_data & DATA_MASK;
		if (a.size_log2 != SIZE_WORD) begin
			r.status = ST_FAULT;
		end else if (a.opcode == OP_READ) begin
			case (a.byte_offset)
				OFF_TOHOST:   r.read_data = tohost;
				OFF_FROMHOST: r.read_data = fromhost;
				OFF_IHALT:    r.read_data = halt_mask;
				OFF_ICONSOLE: r.read_data = console_mask;
				OFF_IYIELD:   r.read_data = yield_mask;
				default:      r.status = ST_FAULT;
			endcase
		end else if (a.byte_offset == OFF_FROMHOST) begin
			fromhost = a.write_data;
		end else if (a.byte_offset == OFF_TOHOST) begin
			tohost = a.write_data;
			if (dev == DEV_HALT) begin
				if (cmd == CMD_HALT && data[0]) begin
					halted   = 1'b1;
					r.status = ST_HALT;
				end
			end else if (dev == DEV_CONSOLE) begin
				if (cmd_on(console_mask, cmd)) begin
					if (cmd == CON_PUTCHAR) begin
						if (!suppress) begin
							r.console_out_valid = 1'b1;
							r.console_out_char  = data[7:0];
						end
						fromhost = ack_word(DEV_CONSOLE, cmd, '0);
					end else if (cmd == CON_GETCHAR) begin
						c = a.console_in_valid ? word_t'(a.console_in_char) + 64'd1 : '0;
						fromhost = ack_word(DEV_CONSOLE, cmd, c);
					end
				end
			end else if (dev == DEV_YIELD) begin
				if (cmd_on(yield_mask, cmd)) begin
					if (cmd == YLD_MANUAL) begin
						yld_manual = 1'b1;
						r.status   = ST_YIELD;
						fromhost   = ack_word(DEV_YIELD, cmd, '0);
					end else if (cmd == YLD_AUTO) begin
						yld_auto = 1'b1;
						r.status = ST_YIELD;
						fromhost = ack_word(DEV_YIELD, cmd, '0);
					end
				end
			end
		end else begin
			r.status = ST_FAULT;
		end
		r.halt_flag         = halted;
		r.manual_yield_flag = yld_manual;
		r.auto_yield_flag   = yld_auto;
		owed_rsp.push_back(r);
	endfunction

	function void field_check(string name, word_t want, word_t got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	// Compare one response transfer with the oldest owed response
	function void check_response(response_t got);
		response_t want;
		if (owed_rsp.size() == 0) begin
			errors++;
			$display("%0t: unexpected response: expected none, actual status %0d data %h",
				$time, got.status, got.read_data);
			return;
		end
		want = owed_rsp.pop_front();
		n_checked++;
		if (want.status == ST_FAULT) n_fault++;
		if (want.status == ST_HALT) n_halt++;
		if (want.status == ST_YIELD) n_yield++;
		if (want.console_out_valid) n_chars++;
		field_check("read_data", want.read_data, got.read_data);
		field_check("status", want.status, got.status);
		field_check("console_out_valid", want.console_out_valid, got.console_out_valid);
		field_check("console_out_char", want.console_out_char, got.console_out_char);
		field_check("halt_flag", want.halt_flag, got.halt_flag);
		field_check("manual_yield_flag", want.manual_yield_flag, got.manual_yield_flag);
		field_check("auto_yield_flag", want.auto_yield_flag, got.auto_yield_flag);
	endfunction
endclass

module tb_top;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 235;
	localparam int HOLD_CYCLES  = 300;
	localparam offset_t REG_OFFSETS [5] = '{OFF_TOHOST, OFF_FROMHOST, OFF_IHALT,
		OFF_ICONSOLE, OFF_IYIELD};

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	word_t    cfg_data;

	int send_idle_pct;
	int rsp_stall_pct;
	int hold_left;
	int cycle_count;

	htif_shadow_model shadow = new();

	htif_req_if req_ch();
	htif_rsp_if rsp_ch();

	htif_host_target_interface #(
		.DEVICE_SHIFT (DEV_SHIFT),
		.COMMAND_SHIFT(CMD_SHIFT)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Response side: check each transfer, then choose ready for the next cycle
	always @(posedge clk) begin
		response_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.read_data         = rsp_ch.read_data;
			got.status            = rsp_ch.status;
			got.console_out_valid = rsp_ch.console_out_valid;
			got.console_out_char  = rsp_ch.console_out_char;
			got.halt_flag         = rsp_ch.halt_flag;
			got.manual_yield_flag = rsp_ch.manual_yield_flag;
			got.auto_yield_flag   = rsp_ch.auto_yield_flag;
			shadow.check_response(got);
		end
		if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic word_t rand_mask();
		case ($urandom_range(4))
			0:       return '0;
			1:       return '1;
			2:       return 64'd3;
			3:       return word_t'($urandom_range(3));
			default: return rand_word();
		endcase
	endfunction

	function automatic access_t mk(logic op, offset_t off, size_t sz, word_t wd,
			logic cv = 1'b0, char_t cc = 8'h00);
		access_t a;
		a.opcode           = op;
		a.byte_offset      = off;
		a.size_log2        = sz;
		a.write_data       = wd;
		a.console_in_valid = cv;
		a.console_in_char  = cc;
		return a;
	endfunction

	// Mostly well-formed tohost commands with random content, some reads and noise
	function automatic access_t random_access();
		access_t a;
		int pick;
		logic [7:0] dev, cmd;
		a = mk(1'($urandom_range(1)), offset_t'($urandom), size_t'($urandom), rand_word(),
			1'($urandom_range(1)), char_t'($urandom));
		pick = $urandom_range(99);
		if (pick < 12) return a;
		a.size_log2 = ($urandom_range(19) == 0) ? size_t'($urandom) : SIZE_WORD;
		a.byte_offset = REG_OFFSETS[$urandom_range(4)];
		if (pick < 32) return a;
		a.opcode = OP_WRITE;
		if (pick < 40) begin
			a.byte_offset = OFF_FROMHOST;
			return a;
		end
		a.byte_offset = OFF_TOHOST;
		case ($urandom_range(9))
			0:       dev = 8'($urandom);
			1, 2:    dev = 8'(DEV_HALT);
			3, 4, 5: dev = 8'(DEV_CONSOLE);
			default: dev = 8'(DEV_YIELD);
		endcase
		case ($urandom_range(7))
			0:       cmd = 8'($urandom);
			1:       cmd = 8'($urandom_range(CMD_SLOTS - 1));
			2, 3, 4: cmd = 8'(CON_GETCHAR);
			default: cmd = 8'(CON_PUTCHAR);
		endcase
		a.write_data = {dev, cmd, a.write_data[47:0]};
		return a;
	endfunction

	// Offer one access, with random idle cycles ahead of it, until it transfers
	task automatic send_access(access_t a);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid            <= 1'b1;
		req_ch.opcode           <= a.opcode;
		req_ch.byte_offset      <= a.byte_offset;
		req_ch.size_log2        <= a.size_log2;
		req_ch.write_data       <= a.write_data;
		req_ch.console_in_valid <= a.console_in_valid;
		req_ch.console_in_char  <= a.console_in_char;
		do @(posedge clk); while (!req_ch.ready);
		shadow.note_access(a);
	endtask

	// Stop offering and wait until every owed response has come back
	task automatic drain(int tail);
		req_ch.valid <= 1'b0;
		while (shadow.owed_rsp.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// Write all four registers, back to back; block must be idle
	task automatic apply_settings(word_t hm, word_t cm, word_t ym, word_t sp);
		word_t vals [4];
		vals = '{hm, cm, ym, sp};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			shadow.set_register(cfg_idx_t'(i), vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
			IDLE_SENDER:   begin send_idle_pct = 81; rsp_stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  rsp_stall_pct = 81; end
			default:       begin send_idle_pct = 13; rsp_stall_pct = 13; end
		endcase
	endtask

	initial begin
		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_index               = REG_HALT_MASK;
		cfg_data                = '0;
		req_ch.valid            = 1'b0;
		req_ch.opcode           = OP_READ;
		req_ch.byte_offset      = OFF_TOHOST;
		req_ch.size_log2        = SIZE_WORD;
		req_ch.write_data       = '0;
		req_ch.console_in_valid = 1'b0;
		req_ch.console_in_char  = '0;
		rsp_ch.ready            = 1'b0;
		hold_left               = 0;
		cycle_count             = 0;
		set_idling(IDLE_NONE);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings: reads, faults, disabled console command
		set_idling(IDLE_BOTH);
		send_access(mk(OP_READ, OFF_TOHOST, SIZE_WORD, '0));
		send_access(mk(OP_READ, OFF_FROMHOST, SIZE_WORD, '0));
		send_access(mk(OP_READ, OFF_IHALT, SIZE_WORD, '0));
		send_access(mk(OP_READ, OFF_ICONSOLE, SIZE_WORD, '0));
		send_access(mk(OP_READ, OFF_IYIELD, SIZE_WORD, '0));
		send_access(mk(OP_READ, 12'hfff, SIZE_WORD, '0));
		send_access(mk(OP_READ, OFF_TOHOST, 2'd0, '0));
		send_access(mk(OP_WRITE, OFF_TOHOST, 2'd2, '1));
		send_access(mk(OP_WRITE, OFF_IHALT, SIZE_WORD, '1));
		send_access(mk(OP_WRITE, OFF_IYIELD, SIZE_WORD, '1));
		send_access(mk(OP_WRITE, OFF_FROMHOST, SIZE_WORD, '1));
		send_access(mk(OP_READ, OFF_FROMHOST, SIZE_WORD, '0));
		send_access(mk(OP_WRITE, OFF_TOHOST, SIZE_WORD,
			{8'(DEV_CONSOLE), 8'(CON_PUTCHAR), 48'h41}));
		send_access(mk(OP_READ, OFF_TOHOST, SIZE_WORD, '0));
		drain(4);

		// Directed, every command enabled: console, unknown devices, yields, halt
		apply_settings(rand_word(), '1, '1, '0);
		send_access(mk(OP_WRITE, OFF_TOHOST, SIZE_WORD,
			{8'(DEV_CONSOLE), 8'(CON_PUTCHAR), 48'hffff_ffff_ffff}));
		send_access(mk(OP_WRITE, OFF_TOHOST, SIZE_WORD,
			{8'(DEV_CONSOLE), 8'(CON_GETCHAR), 48'h0}, 1'b1, 8'hff));
		send_access(mk(OP_WRITE, OFF_TOHOST, SIZE_WORD,
			{8'(DEV_CONSOLE), 8'(CON_GETCHAR), 48'h0}, 1'b0, 8'h5a));
		send_access(mk(OP_WRITE, OFF_TOHOST, SIZE_WORD, {8'(DEV_CONSOLE), 8'hff, 48'h1}));
		send_access(mk(OP_WRITE, OFF_TOHOST, SIZE_WORD, {8'(DEV_CONSOLE), 8'd2, 48'h0}));
		send_access(mk(OP_WRITE, OFF_TOHOST, SIZE_WORD, {8'hff, 8'h00, 48'h1}));
		send_access(mk(OP_WRITE, OFF_TOHOST, SIZE_WORD, {8'(DEV_HALT), 8'd1, 48'h1}));
		send_access(mk(OP_WRITE, OFF_TOHOST, SIZE_WORD, {8'(DEV_YIELD), 8'd64, 48'h0}));
		send_access(mk(OP_WRITE, OFF_TOHOST, SIZE_WORD,
			{8'(DEV_YIELD), 8'(YLD_AUTO), 48'h0}));
		send_access(mk(OP_WRITE, OFF_TOHOST, SIZE_WORD,
			{8'(DEV_YIELD), 8'(YLD_MANUAL), 48'h0}));
		send_access(mk(OP_WRITE, OFF_TOHOST, SIZE_WORD,
			{8'(DEV_HALT), 8'(CMD_HALT), 48'h1}));
		send_access(mk(OP_READ, OFF_FROMHOST, SIZE_WORD, '0));
		drain(4);

		// Random phases, each with its own register setting and idle pattern
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0:       apply_settings('1, '1, '1, '0);
				1:       apply_settings('0, '0, '0, rand_word() | 64'd1);
				2:       apply_settings(64'd3, 64'd3, 64'd3, rand_word() & ~64'd1);
				default: apply_settings(rand_mask(), rand_mask(), rand_mask(), rand_word());
			endcase
			set_idling(idle_mode_t'(p % 4));
			// long receiver hold-off so the block backs up into its input
			if (p == 4) hold_left = HOLD_CYCLES;
			repeat (PHASE_ITEMS) send_access(random_access());
			drain(4);
		end

		drain(10);
		$display("checked %0d responses: %0d faults, %0d halts, %0d yields, %0d chars out",
			shadow.n_checked, shadow.n_fault, shadow.n_halt, shadow.n_yield, shadow.n_chars);
		$display("over %0d register settings and four idle patterns, %0d mismatches",
			RAND_PHASES + 2, shadow.errors);
		if (shadow.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

// File: files.f
+incdir+src
src/htif_pkg.sv
src/htif_ifs.sv
src/htif_host_target_interface.sv
test/tb_top.sv
